>>> src/egcc_pkg.sv
// Shared types and constants for the eye gesture command classifier.
package egcc_pkg;

	localparam int MAG_W     = 16;
	localparam int PX_W      = 6;
	localparam int PY_W      = 5;
	localparam int TIME_W    = 32;
	localparam int RATIO_W   = 8;
	localparam int MAG_SUM_W = 21;
	localparam int X_SUM_W   = 11;
	localparam int Y_SUM_W   = 10;
	localparam int CALIB_W   = 5;
	localparam int PROD_W    = MAG_SUM_W + RATIO_W;

	localparam int BASE_FRAMES  = 29;
	localparam int CALIB_FRAMES = 30;
	localparam int MAG_SCALE    = BASE_FRAMES * 256;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic REG_CLOSE_RATIO = 1'b0;
	localparam logic REG_OPEN_RATIO  = 1'b1;

	localparam logic [RATIO_W-1:0] CLOSE_RATIO_RST = 8'd77;
	localparam logic [RATIO_W-1:0] OPEN_RATIO_RST  = 8'd128;

	typedef enum logic [2:0] {
		CMD_CENTER  = 3'd0,
		CMD_RIGHT   = 3'd1,
		CMD_LEFT    = 3'd2,
		CMD_UP      = 3'd3,
		CMD_DOWN    = 3'd4,
		CMD_CONFIRM = 3'd5,
		CMD_INIT    = 3'd6
	} cmd_t;

	typedef struct packed {
		logic emit;
		cmd_t cmd;
	} decision_t;

endpackage

>>> src/egcc_regs.sv
// Configuration register file: close and open ratio thresholds.
module egcc_regs import egcc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [RATIO_W-1:0]    close_ratio,
	output logic [RATIO_W-1:0]    open_ratio
);

	logic [RATIO_W-1:0] close_ratio_q;
	logic [RATIO_W-1:0] open_ratio_q;
	logic               wr_en;
	logic               reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_ratio_q <= CLOSE_RATIO_RST;
			open_ratio_q  <= OPEN_RATIO_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_CLOSE_RATIO: close_ratio_q <= pwdata[RATIO_W-1:0];
				REG_OPEN_RATIO:  open_ratio_q  <= pwdata[RATIO_W-1:0];
				default:         close_ratio_q <= close_ratio_q;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_CLOSE_RATIO: prdata[RATIO_W-1:0] = close_ratio_q;
			REG_OPEN_RATIO:  prdata[RATIO_W-1:0] = open_ratio_q;
			default:         prdata = '0;
		endcase
	end

	assign close_ratio = close_ratio_q;
	assign open_ratio  = open_ratio_q;

endmodule

>>> src/egcc_core.sv
// Classifier state and per-frame decision logic (baseline, blink, gaze).
module egcc_core import egcc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic [MAG_W-1:0]   magnitude,
	input  logic [PX_W-1:0]    pupil_x,
	input  logic [PY_W-1:0]    pupil_y,
	input  logic [TIME_W-1:0]  now_seconds,
	input  logic [RATIO_W-1:0] close_ratio,
	input  logic [RATIO_W-1:0] open_ratio,
	output decision_t          decision
);

	localparam logic signed [12:0] RIGHT_TH   = 13'sd116;
	localparam logic signed [12:0] LEFT_TH    = -13'sd174;
	localparam logic signed [11:0] DOWN_TH    = 12'sd115;
	localparam logic signed [11:0] UP_TH      = -12'sd115;
	localparam logic signed [12:0] BOX_X_LO   = -13'sd116;
	localparam logic signed [12:0] BOX_X_HI   = 13'sd145;
	localparam logic signed [11:0] BOX_Y_LO   = -12'sd87;
	localparam logic signed [11:0] BOX_Y_HI   = 12'sd87;

	logic [CALIB_W-1:0]   calib_q,   calib_d;
	logic [MAG_SUM_W-1:0] mag_sum_q, mag_sum_d;
	logic [X_SUM_W-1:0]   x_sum_q,   x_sum_d;
	logic [Y_SUM_W-1:0]   y_sum_q,   y_sum_d;
	logic                 eye_open_q, eye_open_d;
	logic                 gaze_held_q, gaze_held_d;
	logic [1:0]           blinks_q,  blinks_d;
	logic [TIME_W-1:0]    last_blink_q, last_blink_d;

	logic [PROD_W-1:0]    scaled;
	logic [PROD_W-1:0]    close_prod;
	logic [PROD_W-1:0]    open_prod;
	logic                 is_closed;
	logic                 is_open;
	logic [X_SUM_W-1:0]   px29;
	logic [Y_SUM_W-1:0]   py29;
	logic signed [12:0]   dx;
	logic signed [11:0]   dy;
	logic [1:0]           blinks_dec;
	logic [TIME_W-1:0]    since_blink;
	logic                 in_box;

	assign scaled     = PROD_W'(magnitude) * PROD_W'(MAG_SCALE);
	assign close_prod = PROD_W'(mag_sum_q) * PROD_W'(close_ratio);
	assign open_prod  = PROD_W'(mag_sum_q) * PROD_W'(open_ratio);
	assign is_closed  = eye_open_q && (scaled < close_prod);
	assign is_open    = scaled > open_prod;

	assign px29 = X_SUM_W'(pupil_x) * X_SUM_W'(BASE_FRAMES);
	assign py29 = Y_SUM_W'(pupil_y) * Y_SUM_W'(BASE_FRAMES);
	assign dx   = $signed({2'b00, px29}) - $signed({2'b00, x_sum_q});
	assign dy   = $signed({2'b00, py29}) - $signed({2'b00, y_sum_q});

	assign blinks_dec  = blinks_q - 2'd1;
	assign since_blink = now_seconds - last_blink_q;
	assign in_box      = (dx > BOX_X_LO) && (dx < BOX_X_HI) &&
	                     (dy > BOX_Y_LO) && (dy < BOX_Y_HI);

	always_comb begin
		decision     = '{emit: 1'b0, cmd: CMD_CENTER};
		calib_d      = calib_q;
		mag_sum_d    = mag_sum_q;
		x_sum_d      = x_sum_q;
		y_sum_d      = y_sum_q;
		eye_open_d   = eye_open_q;
		gaze_held_d  = gaze_held_q;
		blinks_d     = blinks_q;
		last_blink_d = last_blink_q;

		if (calib_q != '0) begin
			calib_d = calib_q - CALIB_W'(1);
			if (calib_q != CALIB_W'(CALIB_FRAMES)) begin
				mag_sum_d = mag_sum_q + MAG_SUM_W'(magnitude);
				x_sum_d   = x_sum_q + X_SUM_W'(pupil_x);
				y_sum_d   = y_sum_q + Y_SUM_W'(pupil_y);
				if (calib_q == CALIB_W'(1))
					decision = '{emit: 1'b1, cmd: CMD_INIT};
			end
		end else if (is_closed) begin
			eye_open_d = 1'b0;
			if (blinks_dec == 2'd0) begin
				blinks_d = 2'd2;
				if (since_blink < TIME_W'(2))
					decision = '{emit: 1'b1, cmd: CMD_CONFIRM};
			end else begin
				blinks_d     = blinks_dec;
				last_blink_d = now_seconds;
			end
		end else if (is_open) begin
			eye_open_d = 1'b1;
			if (!gaze_held_q) begin
				priority if (dx > RIGHT_TH)
					decision = '{emit: 1'b1, cmd: CMD_RIGHT};
				else if (dx < LEFT_TH)
					decision = '{emit: 1'b1, cmd: CMD_LEFT};
				else if (dy > DOWN_TH)
					decision = '{emit: 1'b1, cmd: CMD_DOWN};
				else if (dy < UP_TH)
					decision = '{emit: 1'b1, cmd: CMD_UP};
				else
					decision = '{emit: 1'b0, cmd: CMD_CENTER};
				if (decision.emit) begin
					gaze_held_d = 1'b1;
					blinks_d    = 2'd2;
				end
			end else if (in_box) begin
				gaze_held_d = 1'b0;
				decision    = '{emit: 1'b1, cmd: CMD_CENTER};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_q      <= CALIB_W'(CALIB_FRAMES);
			mag_sum_q    <= '0;
			x_sum_q      <= '0;
			y_sum_q      <= '0;
			eye_open_q   <= 1'b0;
			gaze_held_q  <= 1'b0;
			blinks_q     <= 2'd2;
			last_blink_q <= '0;
		end else if (advance) begin
			calib_q      <= calib_d;
			mag_sum_q    <= mag_sum_d;
			x_sum_q      <= x_sum_d;
			y_sum_q      <= y_sum_d;
			eye_open_q   <= eye_open_d;
			gaze_held_q  <= gaze_held_d;
			blinks_q     <= blinks_d;
			last_blink_q <= last_blink_d;
		end
	end

endmodule

>>> src/eye_gesture_command_classifier.sv
// Top level: input register, classifier core, result register, config port.
//
//  port group  | kind        | moves
//  ------------+-------------+-----------------------------------------------
//  in_*        | valid/ready | magnitude, pupil_x, pupil_y, now_seconds
//  out_*       | valid/ready | command
//  apb         | APB access  | close_ratio @0x0, open_ratio @0x4
//
// A frame is registered on transfer and decided once the result register can
// take it; the state then updates and any command lands in the result register.
// One frame per cycle is sustained while out_ready stays high. A full result
// register that is not taken holds the input register, which then drops in_ready.
// Reset clears all classifier state; calibration restarts with the next frame.
module eye_gesture_command_classifier import egcc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [MAG_W-1:0]      magnitude,
	input  logic [PX_W-1:0]       pupil_x,
	input  logic [PY_W-1:0]       pupil_y,
	input  logic [TIME_W-1:0]     now_seconds,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            command,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic               valid_s1;
	logic [MAG_W-1:0]   magnitude_s1;
	logic [PX_W-1:0]    pupil_x_s1;
	logic [PY_W-1:0]    pupil_y_s1;
	logic [TIME_W-1:0]  now_seconds_s1;
	logic               out_valid_q;
	cmd_t               command_q;
	logic               advance;
	decision_t          decision;
	logic [RATIO_W-1:0] close_ratio;
	logic [RATIO_W-1:0] open_ratio;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			magnitude_s1   <= magnitude;
			pupil_x_s1     <= pupil_x;
			pupil_y_s1     <= pupil_y;
			now_seconds_s1 <= now_seconds;
		end
	end

	egcc_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.close_ratio (close_ratio),
		.open_ratio  (open_ratio)
	);

	egcc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.magnitude   (magnitude_s1),
		.pupil_x     (pupil_x_s1),
		.pupil_y     (pupil_y_s1),
		.now_seconds (now_seconds_s1),
		.close_ratio (close_ratio),
		.open_ratio  (open_ratio),
		.decision    (decision)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= decision.emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && decision.emit)
			command_q <= decision.cmd;
	end

	assign out_valid = out_valid_q;
	assign command   = command_q;

endmodule

>>> dv/eye_gesture_command_classifier_tb.sv
// Self-checking testbench for the eye gesture command classifier: frame stream, APB ratios, command check.
module eye_gesture_command_classifier_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import egcc_pkg::*;

	typedef struct packed {
		logic [MAG_W-1:0]  mag;
		logic [PX_W-1:0]   px;
		logic [PY_W-1:0]   py;
		logic [TIME_W-1:0] now;
	} frame_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [MAG_W-1:0]      magnitude   = '0;
	logic [PX_W-1:0]       pupil_x     = '0;
	logic [PY_W-1:0]       pupil_y     = '0;
	logic [TIME_W-1:0]     now_seconds = '0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [2:0]            command;
	logic                  psel        = 1'b0;
	logic                  penable     = 1'b0;
	logic                  pwrite      = 1'b0;
	logic [APB_ADDR_W-1:0] paddr       = '0;
	logic [APB_DATA_W-1:0] pwdata      = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	eye_gesture_command_classifier u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.magnitude   (magnitude),
		.pupil_x     (pupil_x),
		.pupil_y     (pupil_y),
		.now_seconds (now_seconds),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.command     (command),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// classifier state as it stands after reset
	logic [RATIO_W-1:0]   close_thr          = CLOSE_RATIO_RST;
	logic [RATIO_W-1:0]   open_thr           = OPEN_RATIO_RST;
	logic [CALIB_W-1:0]   frames_to_baseline = CALIB_W'(CALIB_FRAMES);
	logic [MAG_SUM_W-1:0] baseline_mag       = '0;
	logic [X_SUM_W-1:0]   baseline_x         = '0;
	logic [Y_SUM_W-1:0]   baseline_y         = '0;
	bit                   eye_is_open        = 1'b0;
	bit                   gaze_active        = 1'b0;
	logic [1:0]           blinks_to_confirm  = 2'd2;
	logic [TIME_W-1:0]    blink_start_time   = '0;

	cmd_t   pending_cmds[$];
	frame_t frames_to_send[$];
	bit     frame_taken;
	int     in_idle_pct;
	int     out_idle_pct;
	int     errors;
	int     frames_made;
	int     frames_taken;
	int     cmd_count[8];

	int                base_mag;
	int                base_x;
	int                base_y;
	logic [TIME_W-1:0] now_t;

	task automatic classify_frame(input frame_t f);
		logic [63:0]       scaled;
		int                dx;
		int                dy;
		logic [TIME_W-1:0] gap;
		cmd_t              dir;
		scaled = 64'(f.mag) * 64'(MAG_SCALE);
		if (frames_to_baseline != 0) begin
			frames_to_baseline--;
			if (frames_to_baseline == CALIB_FRAMES - 1)
				return;
			baseline_mag += f.mag;
			baseline_x   += f.px;
			baseline_y   += f.py;
			if (frames_to_baseline == 0)
				pending_cmds.push_back(CMD_INIT);
			return;
		end
		if (eye_is_open && scaled < 64'(baseline_mag) * 64'(close_thr)) begin
			eye_is_open = 1'b0;
			blinks_to_confirm = blinks_to_confirm - 2'd1;
			if (blinks_to_confirm == 0) begin
				blinks_to_confirm = 2'd2;
				gap = f.now - blink_start_time;
				if (gap < 2)
					pending_cmds.push_back(CMD_CONFIRM);
			end else begin
				blink_start_time = f.now;
			end
			return;
		end
		if (scaled <= 64'(baseline_mag) * 64'(open_thr))
			return;
		eye_is_open = 1'b1;
		dx = int'(f.px) * BASE_FRAMES - int'(baseline_x);
		dy = int'(f.py) * BASE_FRAMES - int'(baseline_y);
		if (!gaze_active) begin
			// vertical limit is 3.97 frames, i.e. 115 on the x29 scale
			if (dx > 4 * BASE_FRAMES)
				dir = CMD_RIGHT;
			else if (dx < -6 * BASE_FRAMES)
				dir = CMD_LEFT;
			else if (dy > 4 * BASE_FRAMES - 1)
				dir = CMD_DOWN;
			else if (dy < -(4 * BASE_FRAMES - 1))
				dir = CMD_UP;
			else
				return;
			blinks_to_confirm = 2'd2;
			gaze_active = 1'b1;
			pending_cmds.push_back(dir);
		end else if (dx > -4 * BASE_FRAMES && dx < 5 * BASE_FRAMES &&
			dy > -3 * BASE_FRAMES && dy < 3 * BASE_FRAMES) begin
			gaze_active = 1'b0;
			pending_cmds.push_back(CMD_CENTER);
		end
	endtask

	task automatic add_frame(input int m, input int x, input int y);
		frame_t f;
		f.mag = m[MAG_W-1:0];
		f.px  = x[PX_W-1:0];
		f.py  = y[PY_W-1:0];
		f.now = now_t;
		frames_to_send.push_back(f);
		frames_made++;
		now_t += $urandom_range(1);
	endtask

	function automatic int open_mag();
		return base_mag - base_mag / 32 + $urandom_range(base_mag / 8);
	endfunction

	function automatic int closed_mag();
		return $urandom_range(base_mag / 5);
	endfunction

	task automatic look(input cmd_t dir);
		case (dir)
			CMD_RIGHT: add_frame(open_mag(), base_x + $urandom_range(12, 6), base_y);
			CMD_LEFT:  add_frame(open_mag(), base_x - $urandom_range(14, 8), base_y);
			CMD_DOWN:  add_frame(open_mag(), base_x, base_y + $urandom_range(8, 5));
			CMD_UP:    add_frame(open_mag(), base_x, base_y - $urandom_range(8, 5));
			default:   add_frame(open_mag(), base_x, base_y);
		endcase
	endtask

	task automatic blink_pair(input int gap);
		logic [TIME_W-1:0] t0;
		t0 = now_t;
		add_frame(closed_mag(), base_x, base_y);
		look(CMD_CENTER);
		now_t = t0 + gap;
		add_frame(closed_mag(), base_x, base_y);
	endtask

	task automatic apb_access(input logic wr, input logic sel, input logic [RATIO_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {sel, 2'b00};
		pwdata  <= APB_DATA_W'(val);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (wr) begin
			if (sel == REG_CLOSE_RATIO)
				close_thr = val;
			else
				open_thr = val;
		end else if (prdata !== APB_DATA_W'(val)) begin
			errors++;
			$display("%0t: ratio readback at %0d, expected %0d, got %0d",
				$time, sel, val, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_ratios(input logic [RATIO_W-1:0] close_set, input logic [RATIO_W-1:0] open_set);
		apb_access(1'b1, REG_CLOSE_RATIO, close_set);
		apb_access(1'b1, REG_OPEN_RATIO, open_set);
		apb_access(1'b0, REG_CLOSE_RATIO, close_set);
		apb_access(1'b0, REG_OPEN_RATIO, open_set);
	endtask

	task automatic wait_idle();
		while (frames_to_send.size() != 0 || in_valid || pending_cmds.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	always @(negedge clk) begin
		frame_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || frame_taken) begin
			if (frames_to_send.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
				nxt = frames_to_send.pop_front();
				in_valid    <= 1'b1;
				magnitude   <= nxt.mag;
				pupil_x     <= nxt.px;
				pupil_y     <= nxt.py;
				now_seconds <= nxt.now;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= ($urandom_range(99) >= out_idle_pct);
	end

	always @(posedge clk) begin
		cmd_t want;
		frame_taken = 1'b0;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				frame_taken = 1'b1;
				frames_taken++;
				classify_frame({magnitude, pupil_x, pupil_y, now_seconds});
			end
			if (out_valid && out_ready) begin
				if (pending_cmds.size() == 0) begin
					errors++;
					$display("%0t: command transfer with none expected, got %0d",
						$time, command);
				end else begin
					want = pending_cmds.pop_front();
					if (command !== want) begin
						errors++;
						$display("%0t: command mismatch, expected %s (%0d), got %0d",
							$time, want.name(), want, command);
					end
				end
				if (!$isunknown(command))
					cmd_count[command]++;
			end
		end
	end

	initial begin
		int target;
		logic [RATIO_W-1:0] close_set;
		logic [RATIO_W-1:0] open_set;
		base_mag = $urandom_range(56000, 8000);
		base_x   = $urandom_range(35, 15);
		base_y   = $urandom_range(16, 8);
		now_t    = $urandom();

		// calibration: first frame dropped, next 29 form the baseline
		add_frame(65535, 63, 31);
		repeat (29)
			add_frame(base_mag - base_mag / 64 + $urandom_range(base_mag / 32),
				base_x + $urandom_range(1), base_y + $urandom_range(1));

		look(CMD_CENTER);
		look(CMD_RIGHT);
		look(CMD_CENTER);
		look(CMD_LEFT);
		look(CMD_CENTER);
		look(CMD_DOWN);
		look(CMD_CENTER);
		look(CMD_UP);
		look(CMD_CENTER);
		blink_pair(1);
		look(CMD_CENTER);
		blink_pair(2);
		add_frame(65535, 63, 31);
		add_frame(0, 0, 0);
		add_frame(65535, 0, 0);
		look(CMD_CENTER);
		look(CMD_UP);
		look(CMD_CENTER);
		// blink pair straddling the seconds wrap
		now_t = '1;
		blink_pair(1);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int s = 0; s < 9; s++) begin
			in_idle_pct  = (s < 3) ? 27 : (s < 6) ? 48 : 0;
			out_idle_pct = (s < 3) ? 48 : (s < 6) ? 27 : 0;
			if (s != 0) begin
				wait_idle();
				case (s)
					1: begin close_set = 8'd0;   open_set = 8'd255; end
					2: begin close_set = 8'd255; open_set = 8'd0;   end
					3: begin close_set = 8'd100; open_set = 8'd160; end
					4: begin close_set = 8'd255; open_set = 8'd255; end
					5: begin close_set = 8'd0;   open_set = 8'd0;   end
					6: begin close_set = 8'd200; open_set = 8'd100; end
					7: begin
						close_set = $urandom_range(255);
						open_set  = $urandom_range(255);
					end
					default: begin
						close_set = CLOSE_RATIO_RST;
						open_set  = OPEN_RATIO_RST;
					end
				endcase
				set_ratios(close_set, open_set);
			end
			target = frames_made + 190;
			while (frames_made < target) begin
				case ($urandom_range(9))
					0, 1, 2: begin
						look(cmd_t'($urandom_range(4, 1)));
						repeat ($urandom_range(2)) look(cmd_t'($urandom_range(4, 1)));
						look(CMD_CENTER);
					end
					3, 4, 5: begin
						look(CMD_CENTER);
						blink_pair($urandom_range(3));
					end
					6: look(CMD_CENTER);
					7: begin
						now_t = $urandom();
						add_frame($urandom_range(65535), $urandom_range(63), $urandom_range(31));
					end
					8: begin
						now_t = '1 - $urandom_range(2);
						look(CMD_CENTER);
						blink_pair($urandom_range(3));
					end
					default: begin
						if ($urandom_range(1))
							add_frame(closed_mag(), base_x, base_y);
						else
							look(cmd_t'($urandom_range(4, 1)));
					end
				endcase
			end
		end

		wait_idle();
		$display("Sent %0d frames over 9 ratio settings and 3 handshake idle profiles",
			frames_taken);
		$display("Commands: init %0d, confirm %0d, center %0d, right %0d, left %0d, up %0d, down %0d",
			cmd_count[CMD_INIT], cmd_count[CMD_CONFIRM], cmd_count[CMD_CENTER],
			cmd_count[CMD_RIGHT], cmd_count[CMD_LEFT], cmd_count[CMD_UP], cmd_count[CMD_DOWN]);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
